// File: design/ubxfp_pkg.sv
// Shared types, codes and payload maps for the UBX frame parser.
// No dependencies; used by every module in the design folder.
package ubxfp_pkg;

    // Parse phases; codes 11..15 are never entered and behave as hunt
    typedef enum logic [3:0] {
        PH_HUNT     = 4'd0,
        PH_SYNC1    = 4'd1,
        PH_SYNC2    = 4'd2,
        PH_CLASS    = 4'd3,
        PH_ID       = 4'd4,
        PH_LEN_HI   = 4'd5,
        PH_PAYLOAD  = 4'd6,
        PH_ACKCLASS = 4'd7,
        PH_ACKID    = 4'd8,
        PH_CHECK2   = 4'd9,
        PH_ECHO     = 4'd10
    } t_phase;

    // Payload routing selected at the second length byte
    typedef enum logic [2:0] {
        RT_SKIP   = 3'd0,
        RT_POSLLH = 3'd1,
        RT_DOP    = 3'd2,
        RT_SOL    = 3'd3,
        RT_VELNED = 3'd4
    } t_route;

    // Protocol bytes
    localparam logic [7:0] SYNC_CHAR1   = 8'hB5;
    localparam logic [7:0] SYNC_CHAR2   = 8'h62;
    localparam logic [7:0] NMEA_START   = 8'h24;
    localparam logic [7:0] NMEA_LF      = 8'h0A;
    localparam logic [7:0] CLASS_NAV    = 8'h01;
    localparam logic [7:0] CLASS_ACK    = 8'h05;
    localparam logic [7:0] ID_ACK_ACK   = 8'h01;
    localparam logic [7:0] ID_POSLLH    = 8'h02;
    localparam logic [7:0] ID_DOP       = 8'h04;
    localparam logic [7:0] ID_SOL       = 8'h06;
    localparam logic [7:0] ID_VELNED    = 8'h12;

    // Expected payload lengths of routed NAV frames
    localparam logic [15:0] LEN_POSLLH  = 16'd28;
    localparam logic [15:0] LEN_DOP     = 16'd18;
    localparam logic [15:0] LEN_SOL     = 16'd52;
    localparam logic [15:0] LEN_VELNED  = 16'd36;

    // Configuration register indexes
    localparam logic [1:0] CFG_PASSTHRU  = 2'd0;
    localparam logic [1:0] CFG_HIGH_RATE = 2'd1;
    localparam logic [1:0] CFG_ECHO_LIM  = 2'd2;
    localparam logic [7:0] ECHO_LIM_RST  = 8'd128;

    // Store target codes
    localparam logic [3:0] TGT_TOW      = 4'd0;
    localparam logic [3:0] TGT_WEEK     = 4'd1;
    localparam logic [3:0] TGT_FIX      = 4'd2;
    localparam logic [3:0] TGT_NUMSV    = 4'd3;
    localparam logic [3:0] TGT_HDOP     = 4'd4;
    localparam logic [3:0] TGT_LON      = 4'd5;
    localparam logic [3:0] TGT_LAT      = 4'd6;
    localparam logic [3:0] TGT_HMSL     = 4'd7;
    localparam logic [3:0] TGT_VELD     = 4'd8;
    localparam logic [3:0] TGT_AIRSPD   = 4'd9;
    localparam logic [3:0] TGT_GSPEED   = 4'd10;
    localparam logic [3:0] TGT_HEADING  = 4'd11;
    localparam logic [3:0] TGT_ACKCLASS = 4'd12;
    localparam logic [3:0] TGT_ACKID    = 4'd13;

    typedef struct packed {
        logic       passthru;
        logic       high_rate;
        logic [7:0] echo_limit;
    } t_cfg;

    typedef struct packed {
        logic       hit;
        logic [3:0] target;
        logic [1:0] lane;
    } t_map_entry;

    // One result item
    typedef struct packed {
        logic       echo_valid;
        logic [7:0] echo_byte;
        logic       store_valid;
        logic [3:0] store_target;
        logic [1:0] store_lane;
        logic [7:0] store_byte;
        logic       frame_end;
        logic       checksum_ok;
        logic [7:0] frame_class;
        logic [7:0] frame_id;
        logic       nav_trigger;
    } t_result;

    // Payload offset to target/lane maps; offsets past the frame miss
    function automatic t_map_entry map_lookup(input t_route route, input logic [5:0] off);
        t_map_entry e;
        e.hit    = 1'b0;
        e.target = TGT_TOW;
        e.lane   = off[1:0];
        unique case (route)
            RT_POSLLH: begin
                if (off[5:2] == 4'd1) begin
                    e.hit = 1'b1; e.target = TGT_LON;
                end else if (off[5:2] == 4'd2) begin
                    e.hit = 1'b1; e.target = TGT_LAT;
                end else if (off[5:2] == 4'd4) begin
                    e.hit = 1'b1; e.target = TGT_HMSL;
                end
            end
            RT_DOP: begin
                if (off == 6'd12 || off == 6'd13) begin
                    e.hit = 1'b1; e.target = TGT_HDOP; e.lane = {1'b0, off[0]};
                end
            end
            RT_SOL: begin
                if (off[5:2] == 4'd0) begin
                    e.hit = 1'b1; e.target = TGT_TOW;
                end else if (off == 6'd8 || off == 6'd9) begin
                    e.hit = 1'b1; e.target = TGT_WEEK; e.lane = {1'b0, off[0]};
                end else if (off == 6'd10) begin
                    e.hit = 1'b1; e.target = TGT_FIX; e.lane = 2'd0;
                end else if (off == 6'd47) begin
                    e.hit = 1'b1; e.target = TGT_NUMSV; e.lane = 2'd0;
                end
            end
            RT_VELNED: begin
                if (off[5:2] == 4'd3) begin
                    e.hit = 1'b1; e.target = TGT_VELD;
                end else if (off[5:2] == 4'd4) begin
                    e.hit = 1'b1; e.target = TGT_AIRSPD;
                end else if (off[5:2] == 4'd5) begin
                    e.hit = 1'b1; e.target = TGT_GSPEED;
                end else if (off[5:2] == 4'd6) begin
                    e.hit = 1'b1; e.target = TGT_HEADING;
                end
            end
            default: begin
                e.hit = 1'b0;
            end
        endcase
        return e;
    endfunction

endpackage

// File: design/ubxfp_parser.sv
// Byte-wise UBX/NMEA parse state machine and result decode.
// Depends on ubxfp_pkg (phase/route enums, map_lookup, protocol codes).
module ubxfp_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_rx_byte,
    input  ubxfp_pkg::t_cfg    i_cfg,
    output ubxfp_pkg::t_result o_result
);

    ubxfp_pkg::t_phase r_phase, n_phase;
    ubxfp_pkg::t_route r_route, n_route;
    logic [7:0]  r_echo_count, n_echo_count;
    logic [15:0] r_bytes_left, n_bytes_left;
    logic [5:0]  r_store_offset, n_store_offset;
    logic [7:0]  r_sum_a, n_sum_a;
    logic [7:0]  r_sum_b, n_sum_b;
    logic [7:0]  r_first_check, n_first_check;
    logic [7:0]  r_class, n_class;
    logic [7:0]  r_id, n_id;

    logic [7:0] w_sum_a_add;
    logic [7:0] w_sum_b_add;
    logic       w_hunt;
    logic       w_echo_start;
    logic       w_echo_now;
    logic [7:0] w_count_base;
    logic [7:0] w_count_dec;
    logic       w_check_ok;
    ubxfp_pkg::t_map_entry w_map;

    // Fletcher running sums with the current byte folded in
    assign w_sum_a_add = r_sum_a + i_rx_byte;
    assign w_sum_b_add = r_sum_b + w_sum_a_add;

    // Any phase code outside the parse/echo set behaves as hunt
    assign w_hunt = (r_phase == ubxfp_pkg::PH_HUNT) || (r_phase > ubxfp_pkg::PH_ECHO);

    // Echo control: '$' opens a line when both enables are set
    assign w_echo_start = w_hunt && (i_rx_byte != ubxfp_pkg::SYNC_CHAR1)
                        && i_cfg.passthru && i_cfg.high_rate
                        && (i_rx_byte == ubxfp_pkg::NMEA_START);
    assign w_echo_now   = w_echo_start || (r_phase == ubxfp_pkg::PH_ECHO);
    assign w_count_base = w_echo_start
                        ? ((i_cfg.echo_limit == 8'd0) ? 8'd1 : i_cfg.echo_limit)
                        : r_echo_count;
    assign w_count_dec  = w_count_base - 8'd1;

    assign w_map      = ubxfp_pkg::map_lookup(r_route, r_store_offset);
    assign w_check_ok = (r_first_check == r_sum_a) && (i_rx_byte == r_sum_b);

    // Next-state and datapath update
    always_comb begin
        n_phase        = r_phase;
        n_route        = r_route;
        n_echo_count   = r_echo_count;
        n_bytes_left   = r_bytes_left;
        n_store_offset = r_store_offset;
        n_sum_a        = r_sum_a;
        n_sum_b        = r_sum_b;
        n_first_check  = r_first_check;
        n_class        = r_class;
        n_id           = r_id;
        unique case (r_phase)
            ubxfp_pkg::PH_SYNC1: begin
                if (i_rx_byte == ubxfp_pkg::SYNC_CHAR2) begin
                    n_store_offset = 6'd0;
                    n_phase        = ubxfp_pkg::PH_SYNC2;
                end else begin
                    n_phase = ubxfp_pkg::PH_HUNT;
                end
            end
            ubxfp_pkg::PH_SYNC2: begin
                // sums restart at the class byte
                n_class = i_rx_byte;
                n_sum_a = i_rx_byte;
                n_sum_b = i_rx_byte;
                n_phase = ubxfp_pkg::PH_CLASS;
            end
            ubxfp_pkg::PH_CLASS: begin
                n_id    = i_rx_byte;
                n_sum_a = w_sum_a_add;
                n_sum_b = w_sum_b_add;
                n_phase = ubxfp_pkg::PH_ID;
            end
            ubxfp_pkg::PH_ID: begin
                n_bytes_left = {8'd0, i_rx_byte};
                n_sum_a      = w_sum_a_add;
                n_sum_b      = w_sum_b_add;
                n_phase      = ubxfp_pkg::PH_LEN_HI;
            end
            ubxfp_pkg::PH_LEN_HI: begin
                n_bytes_left = {i_rx_byte, r_bytes_left[7:0]};
                n_sum_a      = w_sum_a_add;
                n_sum_b      = w_sum_b_add;
                n_route      = ubxfp_pkg::RT_SKIP;
                n_phase      = ubxfp_pkg::PH_PAYLOAD;
                if (r_class == ubxfp_pkg::CLASS_NAV) begin
                    // routed NAV frame with a wrong length drops back to hunt
                    if (r_id == ubxfp_pkg::ID_POSLLH) begin
                        if (n_bytes_left == ubxfp_pkg::LEN_POSLLH) begin
                            n_route = ubxfp_pkg::RT_POSLLH;
                        end else begin
                            n_phase = ubxfp_pkg::PH_HUNT;
                        end
                    end else if (r_id == ubxfp_pkg::ID_DOP) begin
                        if (n_bytes_left == ubxfp_pkg::LEN_DOP) begin
                            n_route = ubxfp_pkg::RT_DOP;
                        end else begin
                            n_phase = ubxfp_pkg::PH_HUNT;
                        end
                    end else if (r_id == ubxfp_pkg::ID_SOL) begin
                        if (n_bytes_left == ubxfp_pkg::LEN_SOL) begin
                            n_route = ubxfp_pkg::RT_SOL;
                        end else begin
                            n_phase = ubxfp_pkg::PH_HUNT;
                        end
                    end else if (r_id == ubxfp_pkg::ID_VELNED) begin
                        if (n_bytes_left == ubxfp_pkg::LEN_VELNED) begin
                            n_route = ubxfp_pkg::RT_VELNED;
                        end else begin
                            n_phase = ubxfp_pkg::PH_HUNT;
                        end
                    end
                end else if (r_class == ubxfp_pkg::CLASS_ACK) begin
                    n_phase = (r_id <= ubxfp_pkg::ID_ACK_ACK)
                            ? ubxfp_pkg::PH_ACKCLASS : ubxfp_pkg::PH_HUNT;
                end
            end
            ubxfp_pkg::PH_PAYLOAD: begin
                if (r_bytes_left != 16'd0) begin
                    if (r_route != ubxfp_pkg::RT_SKIP) begin
                        n_store_offset = r_store_offset + 6'd1;
                    end
                    n_sum_a      = w_sum_a_add;
                    n_sum_b      = w_sum_b_add;
                    n_bytes_left = r_bytes_left - 16'd1;
                end else begin
                    n_first_check = i_rx_byte;
                    n_phase       = ubxfp_pkg::PH_CHECK2;
                end
            end
            ubxfp_pkg::PH_ACKCLASS: begin
                n_sum_a = w_sum_a_add;
                n_sum_b = w_sum_b_add;
                n_phase = ubxfp_pkg::PH_ACKID;
            end
            ubxfp_pkg::PH_ACKID: begin
                // ACK payload is always two bytes, then the checksum pair
                n_sum_a      = w_sum_a_add;
                n_sum_b      = w_sum_b_add;
                n_bytes_left = 16'd0;
                n_route      = ubxfp_pkg::RT_SKIP;
                n_phase      = ubxfp_pkg::PH_PAYLOAD;
            end
            ubxfp_pkg::PH_CHECK2: begin
                n_phase = ubxfp_pkg::PH_HUNT;
            end
            ubxfp_pkg::PH_ECHO: begin
                n_phase = ubxfp_pkg::PH_ECHO;
            end
            default: begin
                if (i_rx_byte == ubxfp_pkg::SYNC_CHAR1) begin
                    n_phase = ubxfp_pkg::PH_SYNC1;
                end else if (w_echo_start) begin
                    n_phase = ubxfp_pkg::PH_ECHO;
                end
            end
        endcase
        // echo line ends at LF or when the byte budget runs out
        if (w_echo_now) begin
            n_echo_count = w_count_dec;
            if (i_rx_byte == ubxfp_pkg::NMEA_LF || w_count_dec == 8'd0) begin
                n_phase = ubxfp_pkg::PH_HUNT;
            end
        end
    end

    // Result decode for the current byte
    always_comb begin
        o_result = '0;
        if (w_echo_now) begin
            o_result.echo_valid = 1'b1;
            o_result.echo_byte  = i_rx_byte;
        end
        unique case (r_phase)
            ubxfp_pkg::PH_PAYLOAD: begin
                if (r_bytes_left != 16'd0 && w_map.hit) begin
                    o_result.store_valid  = 1'b1;
                    o_result.store_target = w_map.target;
                    o_result.store_lane   = w_map.lane;
                    o_result.store_byte   = i_rx_byte;
                end
            end
            ubxfp_pkg::PH_ACKCLASS: begin
                o_result.store_valid  = 1'b1;
                o_result.store_target = ubxfp_pkg::TGT_ACKCLASS;
                o_result.store_byte   = i_rx_byte;
            end
            ubxfp_pkg::PH_ACKID: begin
                o_result.store_valid  = 1'b1;
                o_result.store_target = ubxfp_pkg::TGT_ACKID;
                o_result.store_byte   = i_rx_byte;
            end
            ubxfp_pkg::PH_CHECK2: begin
                o_result.frame_end   = 1'b1;
                o_result.checksum_ok = w_check_ok;
                o_result.frame_class = r_class;
                o_result.frame_id    = r_id;
                o_result.nav_trigger = w_check_ok && (r_id == ubxfp_pkg::ID_VELNED);
            end
            default: begin
                o_result.store_valid = 1'b0;
            end
        endcase
    end

    // State registers advance on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= ubxfp_pkg::PH_HUNT;
            r_route        <= ubxfp_pkg::RT_SKIP;
            r_echo_count   <= 8'd0;
            r_bytes_left   <= 16'd0;
            r_store_offset <= 6'd0;
            r_sum_a        <= 8'd0;
            r_sum_b        <= 8'd0;
            r_first_check  <= 8'd0;
            r_class        <= 8'd0;
            r_id           <= 8'd0;
        end else if (i_accept) begin
            r_phase        <= n_phase;
            r_route        <= n_route;
            r_echo_count   <= n_echo_count;
            r_bytes_left   <= n_bytes_left;
            r_store_offset <= n_store_offset;
            r_sum_a        <= n_sum_a;
            r_sum_b        <= n_sum_b;
            r_first_check  <= n_first_check;
            r_class        <= n_class;
            r_id           <= n_id;
        end
    end

endmodule

// File: design/ubxfp_out_skid.sv
// Result register with one skid entry between parser and output channel.
// Depends on ubxfp_pkg (t_result).
module ubxfp_out_skid (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  ubxfp_pkg::t_result i_result,
    input  logic               i_stall,
    output logic               o_full,
    output logic               o_valid,
    output ubxfp_pkg::t_result o_result
);

    logic               r_out_valid;
    logic               r_skid_valid;
    ubxfp_pkg::t_result r_out;
    ubxfp_pkg::t_result r_skid;
    logic               w_out_fire;

    assign w_out_fire = r_out_valid && !i_stall;

    // Valid bits: skid fills only when output is held
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_out_fire) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_load) begin
            if (r_out_valid && !w_out_fire) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (w_out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_out_fire) begin
                r_out <= r_skid;
            end
        end else if (i_load) begin
            if (r_out_valid && !w_out_fire) begin
                r_skid <= i_result;
            end else begin
                r_out <= i_result;
            end
        end
    end

    assign o_full   = r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// File: design/ubx_frame_parser_core.sv
// UBX binary frame parser with NMEA echo; top level over ubxfp_parser and ubxfp_out_skid.
// A byte's result is registered: output register, or skid entry while the output is held.
// Throughput: one byte per cycle; the input stalls only when the skid entry is full.
// Reset (synchronous, active low): hunt phase, empty output, config to defaults.
// Depends on ubxfp_pkg.
module ubx_frame_parser_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // config write port
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    // byte input channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    // result channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_echo_valid,
    output logic [7:0] o_echo_byte,
    output logic       o_store_valid,
    output logic [3:0] o_store_target,
    output logic [1:0] o_store_lane,
    output logic [7:0] o_store_byte,
    output logic       o_frame_end,
    output logic       o_checksum_ok,
    output logic [7:0] o_frame_class,
    output logic [7:0] o_frame_id,
    output logic       o_nav_trigger
);

    ubxfp_pkg::t_cfg    r_cfg;
    ubxfp_pkg::t_result w_result;
    ubxfp_pkg::t_result w_out;
    logic               w_full;
    logic               w_accept;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.passthru   <= 1'b0;
            r_cfg.high_rate  <= 1'b0;
            r_cfg.echo_limit <= ubxfp_pkg::ECHO_LIM_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ubxfp_pkg::CFG_PASSTHRU:  r_cfg.passthru   <= i_cfg_data[0];
                ubxfp_pkg::CFG_HIGH_RATE: r_cfg.high_rate  <= i_cfg_data[0];
                ubxfp_pkg::CFG_ECHO_LIM:  r_cfg.echo_limit <= i_cfg_data;
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // Input transfer
    assign o_stall  = w_full;
    assign w_accept = i_valid && !w_full;

    ubxfp_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_rx_byte (i_rx_byte),
        .i_cfg     (r_cfg),
        .o_result  (w_result)
    );

    ubxfp_out_skid u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_accept),
        .i_result (w_result),
        .i_stall  (i_stall),
        .o_full   (w_full),
        .o_valid  (o_valid),
        .o_result (w_out)
    );

    // Output fields
    assign o_echo_valid   = w_out.echo_valid;
    assign o_echo_byte    = w_out.echo_byte;
    assign o_store_valid  = w_out.store_valid;
    assign o_store_target = w_out.store_target;
    assign o_store_lane   = w_out.store_lane;
    assign o_store_byte   = w_out.store_byte;
    assign o_frame_end    = w_out.frame_end;
    assign o_checksum_ok  = w_out.checksum_ok;
    assign o_frame_class  = w_out.frame_class;
    assign o_frame_id     = w_out.frame_id;
    assign o_nav_trigger  = w_out.nav_trigger;

    // Input stalls only behind a held result
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result held");

    // Skid fills only after a stalled result
    a_stall_rise_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("skid filled without output stall");

    // Echo and store never come from the same byte
    a_echo_store_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_echo_valid && o_store_valid))
        else $error("echo and store on one byte");

    // Navigation trigger only on a good VELNED-id frame end
    a_nav_trigger: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_nav_trigger) |-> (o_frame_end && o_checksum_ok
                                        && o_frame_id == ubxfp_pkg::ID_VELNED))
        else $error("nav trigger without good frame end");

endmodule

// File: test/ubx_frame_parser_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the UBX frame parser: follows config writes and byte transfers,
// models the parser state and compares every result transfer. Uses ubxfp_pkg.
module ubx_frame_parser_checker
    import ubxfp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_byte_valid,
    input  logic       i_byte_stall,
    input  logic [7:0] i_rx_byte,
    input  logic       i_res_valid,
    input  logic       i_res_stall,
    input  logic       i_echo_valid,
    input  logic [7:0] i_echo_byte,
    input  logic       i_store_valid,
    input  logic [3:0] i_store_target,
    input  logic [1:0] i_store_lane,
    input  logic [7:0] i_store_byte,
    input  logic       i_frame_end,
    input  logic       i_checksum_ok,
    input  logic [7:0] i_frame_class,
    input  logic [7:0] i_frame_id,
    input  logic       i_nav_trigger,
    output int         o_mismatches,
    output int         o_outstanding
);

    // Parser model state
    t_cfg        cfg;
    t_phase      ph;
    t_route      rt;
    logic [7:0]  echo_left;
    logic [15:0] len_left;
    logic [5:0]  offs;
    logic [7:0]  fl_a, fl_b, ck_first, cls, id;

    // Parsed results waiting for their transfer, oldest first
    t_result     parsed_q[$];
    int          results_seen;

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
        results_seen  = 0;
    end

    task automatic report_mismatch(input string what);
        if (o_mismatches < 100)
            $display("%0t ns: result %0d: %s", $time, results_seen, what);
        o_mismatches++;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
            report_mismatch($sformatf("%s want 0x%0h got 0x%0h", name, want, got));
    endtask

    function automatic void fletcher_add(input logic [7:0] b);
        fl_a = fl_a + b;
        fl_b = fl_b + fl_a;
    endfunction

    // Which target field and lane a payload offset feeds, per routed message
    function automatic t_map_entry lane_of(input t_route r, input logic [5:0] off);
        t_map_entry  m;
        int unsigned o;
        o        = off;
        m.hit    = 1'b0;
        m.target = TGT_TOW;
        m.lane   = 2'(o % 4);
        case (r)
            RT_POSLLH: begin
                if (o >= 4 && o < 12) begin
                    m.hit = 1'b1;
                    m.target = (o < 8) ? TGT_LON : TGT_LAT;
                end else if (o >= 16 && o < 20) begin
                    m.hit = 1'b1;
                    m.target = TGT_HMSL;
                end
            end
            RT_DOP: begin
                if (o == 12 || o == 13) begin
                    m.hit = 1'b1;
                    m.target = TGT_HDOP;
                end
            end
            RT_SOL: begin
                if (o < 4) begin
                    m.hit = 1'b1;
                    m.target = TGT_TOW;
                end else if (o == 8 || o == 9) begin
                    m.hit = 1'b1;
                    m.target = TGT_WEEK;
                end else if (o == 10) begin
                    m.hit = 1'b1;
                    m.target = TGT_FIX;
                    m.lane = 2'd0;
                end else if (o == 47) begin
                    m.hit = 1'b1;
                    m.target = TGT_NUMSV;
                    m.lane = 2'd0;
                end
            end
            RT_VELNED: begin
                if (o >= 12 && o < 28) begin
                    m.hit = 1'b1;
                    m.target = 4'(TGT_VELD + (o - 12) / 4);
                end
            end
            default: begin
                m.hit = 1'b0;
            end
        endcase
        return m;
    endfunction

    // One received byte through the parser model
    task automatic parse_byte(input logic [7:0] b, output t_result r);
        t_map_entry  m;
        logic        echo_now;
        logic [15:0] need;
        r        = '0;
        echo_now = 1'b0;
        need     = '0;
        case (ph)
            PH_SYNC1: begin
                if (b == SYNC_CHAR2) begin
                    offs = '0;
                    ph = PH_SYNC2;
                end else begin
                    ph = PH_HUNT;
                end
            end
            PH_SYNC2: begin
                cls = b;
                fl_a = '0;
                fl_b = '0;
                fletcher_add(b);
                ph = PH_CLASS;
            end
            PH_CLASS: begin
                id = b;
                fletcher_add(b);
                ph = PH_ID;
            end
            PH_ID: begin
                len_left = {8'd0, b};
                fletcher_add(b);
                ph = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                len_left = {b, len_left[7:0]};
                fletcher_add(b);
                rt = RT_SKIP;
                ph = PH_PAYLOAD;
                if (cls == CLASS_NAV) begin
                    case (id)
                        ID_POSLLH: begin rt = RT_POSLLH; need = LEN_POSLLH; end
                        ID_DOP:    begin rt = RT_DOP;    need = LEN_DOP;    end
                        ID_SOL:    begin rt = RT_SOL;    need = LEN_SOL;    end
                        ID_VELNED: begin rt = RT_VELNED; need = LEN_VELNED; end
                        default:   begin rt = RT_SKIP; end
                    endcase
                    // routed message with the wrong length: give up on it
                    if (rt != RT_SKIP && len_left != need) begin
                        rt = RT_SKIP;
                        ph = PH_HUNT;
                    end
                end else if (cls == CLASS_ACK) begin
                    ph = (id <= ID_ACK_ACK) ? PH_ACKCLASS : PH_HUNT;
                end
            end
            PH_PAYLOAD: begin
                if (len_left != 16'd0) begin
                    if (rt != RT_SKIP) begin
                        m = lane_of(rt, offs);
                        if (m.hit) begin
                            r.store_valid  = 1'b1;
                            r.store_target = m.target;
                            r.store_lane   = m.lane;
                            r.store_byte   = b;
                        end
                        offs = offs + 6'd1;
                    end
                    fletcher_add(b);
                    len_left = len_left - 16'd1;
                end else begin
                    ck_first = b;
                    ph = PH_CHECK2;
                end
            end
            PH_ACKCLASS: begin
                r.store_valid  = 1'b1;
                r.store_target = TGT_ACKCLASS;
                r.store_byte   = b;
                fletcher_add(b);
                ph = PH_ACKID;
            end
            PH_ACKID: begin
                // ACK body is always two bytes, whatever the length said
                r.store_valid  = 1'b1;
                r.store_target = TGT_ACKID;
                r.store_byte   = b;
                fletcher_add(b);
                len_left = '0;
                rt = RT_SKIP;
                ph = PH_PAYLOAD;
            end
            PH_CHECK2: begin
                r.frame_end   = 1'b1;
                r.checksum_ok = (ck_first == fl_a) && (b == fl_b);
                r.frame_class = cls;
                r.frame_id    = id;
                r.nav_trigger = r.checksum_ok && (id == ID_VELNED);
                ph = PH_HUNT;
            end
            PH_ECHO: begin
                echo_now = 1'b1;
            end
            default: begin
                if (b == SYNC_CHAR1) begin
                    ph = PH_SYNC1;
                end else if (cfg.passthru && cfg.high_rate && b == NMEA_START) begin
                    echo_left = (cfg.echo_limit != 8'd0) ? cfg.echo_limit : 8'd1;
                    ph = PH_ECHO;
                    echo_now = 1'b1;
                end
            end
        endcase

        // NMEA text echo runs to LF or the byte limit
        if (echo_now) begin
            r.echo_valid = 1'b1;
            r.echo_byte  = b;
            echo_left    = echo_left - 8'd1;
            if (b == NMEA_LF || echo_left == 8'd0)
                ph = PH_HUNT;
        end
    endtask

    // Watch both channels and the register port at each rising edge
    always @(posedge i_clk) begin
        t_result want, got;
        if (!i_rst_n) begin
            cfg.passthru   = 1'b0;
            cfg.high_rate  = 1'b0;
            cfg.echo_limit = ECHO_LIM_RST;
            ph        = PH_HUNT;
            rt        = RT_SKIP;
            echo_left = '0;
            len_left  = '0;
            offs      = '0;
            fl_a      = '0;
            fl_b      = '0;
            ck_first  = '0;
            cls       = '0;
            id        = '0;
            parsed_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PASSTHRU:  cfg.passthru   = i_cfg_data[0];
                    CFG_HIGH_RATE: cfg.high_rate  = i_cfg_data[0];
                    CFG_ECHO_LIM:  cfg.echo_limit = i_cfg_data;
                    default: ;
                endcase
            end

            // result side first: a byte's result never leaves on its own edge
            if (i_res_valid && !i_res_stall) begin
                got.echo_valid   = i_echo_valid;
                got.echo_byte    = i_echo_byte;
                got.store_valid  = i_store_valid;
                got.store_target = i_store_target;
                got.store_lane   = i_store_lane;
                got.store_byte   = i_store_byte;
                got.frame_end    = i_frame_end;
                got.checksum_ok  = i_checksum_ok;
                got.frame_class  = i_frame_class;
                got.frame_id     = i_frame_id;
                got.nav_trigger  = i_nav_trigger;
                if (parsed_q.size() == 0) begin
                    report_mismatch("result transfer with no byte pending");
                end else begin
                    want = parsed_q.pop_front();
                    check_field("echo_valid",   want.echo_valid,   got.echo_valid);
                    check_field("echo_byte",    want.echo_byte,    got.echo_byte);
                    check_field("store_valid",  want.store_valid,  got.store_valid);
                    check_field("store_target", want.store_target, got.store_target);
                    check_field("store_lane",   want.store_lane,   got.store_lane);
                    check_field("store_byte",   want.store_byte,   got.store_byte);
                    check_field("frame_end",    want.frame_end,    got.frame_end);
                    check_field("checksum_ok",  want.checksum_ok,  got.checksum_ok);
                    check_field("frame_class",  want.frame_class,  got.frame_class);
                    check_field("frame_id",     want.frame_id,     got.frame_id);
                    check_field("nav_trigger",  want.nav_trigger,  got.nav_trigger);
                end
                results_seen++;
            end

            if (i_byte_valid && !i_byte_stall) begin
                parse_byte(i_rx_byte, want);
                parsed_q.push_back(want);
            end
        end
        o_outstanding = parsed_q.size();
    end

endmodule

// File: test/ubx_frame_parser_core_tb.sv
`timescale 1ns / 100ps
// Top of the UBX frame parser bench: clock, reset, byte stimulus, result stalls
// and verdict. Depends on ubxfp_pkg, ubx_frame_parser_core and the checker.
module ubx_frame_parser_core_tb;
    import ubxfp_pkg::*;

    localparam int         CYCLE_LIMIT = 200000;
    localparam int         PHASE_BYTES = 350;
    localparam int         HOLD_CYCLES = 300;
    localparam logic [7:0] ID_ACK_NAK  = 8'h00;
    localparam logic [7:0] CLASS_MISC  = 8'h0A;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [7:0] i_cfg_data;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_rx_byte;
    logic       o_valid;
    logic       i_stall;
    logic       o_echo_valid;
    logic [7:0] o_echo_byte;
    logic       o_store_valid;
    logic [3:0] o_store_target;
    logic [1:0] o_store_lane;
    logic [7:0] o_store_byte;
    logic       o_frame_end;
    logic       o_checksum_ok;
    logic [7:0] o_frame_class;
    logic [7:0] o_frame_id;
    logic       o_nav_trigger;

    int         mismatches;
    int         outstanding;
    int         cycle_count = 0;
    int         src_idle_pct = 0;
    int         sink_stall_pct = 0;
    int         bytes_sent = 0;
    int         nav_seq = 0;
    logic       hold_req;
    logic [7:0] tx_q[$];

    ubx_frame_parser_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_echo_valid   (o_echo_valid),
        .o_echo_byte    (o_echo_byte),
        .o_store_valid  (o_store_valid),
        .o_store_target (o_store_target),
        .o_store_lane   (o_store_lane),
        .o_store_byte   (o_store_byte),
        .o_frame_end    (o_frame_end),
        .o_checksum_ok  (o_checksum_ok),
        .o_frame_class  (o_frame_class),
        .o_frame_id     (o_frame_id),
        .o_nav_trigger  (o_nav_trigger)
    );

    ubx_frame_parser_checker u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_byte_valid   (i_valid),
        .i_byte_stall   (o_stall),
        .i_rx_byte      (i_rx_byte),
        .i_res_valid    (o_valid),
        .i_res_stall    (i_stall),
        .i_echo_valid   (o_echo_valid),
        .i_echo_byte    (o_echo_byte),
        .i_store_valid  (o_store_valid),
        .i_store_target (o_store_target),
        .i_store_lane   (o_store_lane),
        .i_store_byte   (o_store_byte),
        .i_frame_end    (o_frame_end),
        .i_checksum_ok  (o_checksum_ok),
        .i_frame_class  (o_frame_class),
        .i_frame_id     (o_frame_id),
        .i_nav_trigger  (o_nav_trigger),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Long receiver hold-off, counted here so the sender keeps pushing
    initial begin
        hold_req = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
        end
    end

    // Result-side stalls
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_stall = hold_req || ($urandom_range(99) < sink_stall_pct);
        end
    end

    // One byte transfer, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid   = 1'b1;
        i_rx_byte = b;
        do @(posedge i_clk); while (o_stall);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_queued();
        while (tx_q.size() != 0)
            send_byte(tx_q.pop_front());
    endtask

    // Sender pause until every result is back, plus the output latency
    task automatic wait_results_done();
        i_valid = 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    task automatic set_echo(input logic pt, input logic hr, input logic [7:0] lim);
        write_reg(CFG_PASSTHRU, {7'd0, pt});
        write_reg(CFG_HIGH_RATE, {7'd0, hr});
        write_reg(CFG_ECHO_LIM, lim);
    endtask

    // Sync, header, body and Fletcher sums; optionally spoil one check byte
    task automatic queue_frame(input logic [7:0] cls, input logic [7:0] id,
                               input logic [15:0] len_field, input int body_len,
                               input logic bad_ck);
        logic [7:0] summed[$];
        logic [7:0] ca, cb;
        ca = 8'd0;
        cb = 8'd0;
        summed = '{cls, id, len_field[7:0], len_field[15:8]};
        for (int i = 0; i < body_len; i++)
            summed.push_back(8'($urandom_range(255)));
        tx_q.push_back(SYNC_CHAR1);
        tx_q.push_back(SYNC_CHAR2);
        foreach (summed[i]) begin
            ca = ca + summed[i];
            cb = cb + ca;
            tx_q.push_back(summed[i]);
        end
        if (bad_ck) begin
            if ($urandom_range(1))
                ca = ca ^ 8'($urandom_range(1, 255));
            else
                cb = cb ^ 8'($urandom_range(1, 255));
        end
        tx_q.push_back(ca);
        tx_q.push_back(cb);
    endtask

    task automatic queue_nmea(input int n, input logic with_lf);
        tx_q.push_back(NMEA_START);
        for (int i = 0; i < n; i++)
            tx_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
        if (with_lf)
            tx_q.push_back(NMEA_LF);
    endtask

    // Mostly well-formed traffic with random content, some broken or noise
    task automatic queue_message();
        int          k;
        int          n;
        logic [7:0]  cls;
        logic [7:0]  id;
        logic [15:0] need;
        k = $urandom_range(99);
        case (nav_seq % 4)
            0:       begin id = ID_POSLLH; need = LEN_POSLLH; end
            1:       begin id = ID_DOP;    need = LEN_DOP;    end
            2:       begin id = ID_SOL;    need = LEN_SOL;    end
            default: begin id = ID_VELNED; need = LEN_VELNED; end
        endcase
        if (k < 30) begin
            nav_seq++;
            queue_frame(CLASS_NAV, id, need, need, $urandom_range(4) == 0);
        end else if (k < 42) begin
            // ACK or NACK, length field sometimes garbage
            queue_frame(CLASS_ACK, $urandom_range(1) ? ID_ACK_ACK : ID_ACK_NAK,
                        $urandom_range(3) == 0 ? 16'($urandom_range(65535)) : 16'd2,
                        2, $urandom_range(5) == 0);
        end else if (k < 55) begin
            cls = $urandom_range(2) == 0 ? CLASS_NAV : 8'($urandom_range(255));
            if (cls == CLASS_ACK)
                cls = CLASS_MISC;
            n = $urandom_range(6);
            queue_frame(cls, 8'($urandom_range(255)), 16'(n), n, $urandom_range(4) == 0);
        end else if (k < 60) begin
            // routed message with a wrong length
            nav_seq++;
            need = $urandom_range(1) ? need + 16'($urandom_range(1, 40))
                                     : need ^ 16'($urandom_range(1, 65535));
            queue_frame(CLASS_NAV, id, need, $urandom_range(8), 1'b0);
        end else if (k < 63) begin
            queue_frame(CLASS_ACK, 8'($urandom_range(2, 255)), 16'd2, 2, 1'b0);
        end else if (k < 67) begin
            tx_q.push_back(SYNC_CHAR1);
            tx_q.push_back($urandom_range(1) ? SYNC_CHAR1 : 8'($urandom_range(255)));
        end else if (k < 82) begin
            queue_nmea($urandom_range(24), $urandom_range(7) != 0);
        end else begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                tx_q.push_back(8'($urandom_range(255)));
        end
    endtask

    initial begin
        int   phase_start;
        logic held;
        logic split;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_PASSTHRU;
        i_cfg_data  = 8'd0;
        i_valid     = 1'b0;
        i_rx_byte   = 8'd0;
        held        = 1'b0;
        split       = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: extremes, broken sync, echo end by LF, ACK/NACK, rejects
        set_echo(1'b1, 1'b1, 8'd8);
        tx_q = '{8'h00, 8'hFF, SYNC_CHAR1, SYNC_CHAR1, SYNC_CHAR2};
        send_queued();
        queue_nmea(2, 1'b1);
        queue_frame(CLASS_ACK, ID_ACK_ACK, 16'd2, 2, 1'b0);
        queue_frame(CLASS_ACK, ID_ACK_NAK, 16'd7, 2, 1'b0);
        queue_frame(CLASS_MISC, 8'h33, 16'd0, 0, 1'b1);
        queue_frame(CLASS_NAV, ID_POSLLH, 16'd5, 0, 1'b0);
        queue_frame(CLASS_ACK, 8'h07, 16'd2, 0, 1'b0);
        send_queued();
        // zero echo limit: only the dollar sign goes out
        wait_results_done();
        write_reg(CFG_ECHO_LIM, 8'd0);
        queue_nmea(2, 1'b0);
        send_queued();

        // Random traffic over four stall patterns and several register settings
        for (int phase = 0; phase < 4; phase++) begin
            wait_results_done();
            case (phase)
                0: begin
                    set_echo(1'b1, 1'b1, 8'd255);
                    src_idle_pct = 0;  sink_stall_pct = 0;
                end
                1: begin
                    set_echo(1'b1, 1'b1, 8'd1);
                    src_idle_pct = 82; sink_stall_pct = 0;
                end
                2: begin
                    set_echo(1'b0, 1'b1, 8'($urandom_range(2, 20)));
                    src_idle_pct = 0;  sink_stall_pct = 82;
                end
                default: begin
                    set_echo(1'b1, 1'b1, 8'($urandom_range(2, 40)));
                    src_idle_pct = 8;  sink_stall_pct = 8;
                end
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                if (phase == 0 && !held && bytes_sent - phase_start > 100) begin
                    hold_req = 1'b1;
                    held = 1'b1;
                end
                if (phase == 2 && !split && bytes_sent - phase_start > PHASE_BYTES / 2) begin
                    wait_results_done();
                    set_echo(1'b1, 1'b0, 8'($urandom_range(1, 255)));
                    split = 1'b1;
                end
                queue_message();
                send_queued();
            end
        end

        wait_results_done();
        repeat (4) @(negedge i_clk);
        if (mismatches == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: filelist.f
design/ubxfp_pkg.sv
design/ubxfp_parser.sv
design/ubxfp_out_skid.sv
design/ubx_frame_parser_core.sv
test/ubx_frame_parser_checker.sv
test/ubx_frame_parser_core_tb.sv
